>>> rtl/selt_pkg.sv
// package for the shared/exclusive lock table: types, codes and constants
`default_nettype none
package selt_pkg;
    localparam int unsigned ENTRIES_DEF       = 64;
    localparam int unsigned RESOURCE_BITS_DEF = 12;
    localparam int unsigned ROUTE_BITS_DEF    = 8;
    localparam int unsigned SEC_PER_MIN       = 60;

    localparam logic [2:0] MODE_LOCK       = 3'd0;
    localparam logic [2:0] MODE_UNLOCK     = 3'd1;
    localparam logic [2:0] MODE_UNLOCK_ALL = 3'd2;
    localparam logic [2:0] MODE_TICK       = 3'd3;
    localparam logic [2:0] MODE_QUERY      = 3'd4;

    localparam logic [1:0] KIND_EXCLUSIVE = 2'd0;
    localparam logic [1:0] KIND_SHARED    = 2'd1;
    localparam logic [1:0] KIND_OVERLAP   = 2'd2;
    localparam logic [1:0] KIND_INVALID   = 2'd3;
    localparam logic [1:0] RES_INVALID    = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DISABLED  = 3'd1;
    localparam logic [2:0] ST_BAD_LOCK  = 3'd2;
    localparam logic [2:0] ST_BAD_RES   = 3'd3;
    localparam logic [2:0] ST_CONFLICT  = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;
    localparam logic [2:0] ST_FULL      = 3'd6;

    localparam logic [1:0] CFG_ENABLED  = 2'd0;
    localparam logic [1:0] CFG_MAX_MIN  = 2'd1;
    localparam logic [1:0] CFG_INTERVAL = 2'd2;

    typedef struct packed {
        logic [2:0]                   mode;
        logic [1:0]                   resource_kind;
        logic [RESOURCE_BITS_DEF-1:0] resource_number;
        logic [ROUTE_BITS_DEF-1:0]    route_number;
        logic [1:0]                   lock_kind;
        logic [15:0]                  timeout_minutes;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  conflict_count;
        logic        is_locked;
        logic [6:0]  live_lock_count;
        logic [31:0] lease_end;
        logic [6:0]  purged_count;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic start;   // latch item, clear counters
        logic scan;    // examine the entry at the scan index
        logic commit;  // apply the item's write or removal
        logic finish;  // build the result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic rd_valid;  // read data of a scan entry is available
        logic last;      // last entry has been examined
    } t_sts;
endpackage
`default_nettype wire

>>> rtl/selt_ram.sv
// generic single-port ram with registered read
`default_nettype none
module selt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

>>> rtl/selt_ctrl.sv
// controller for the lock table: one scan over all entries per transfer
`default_nettype none
module selt_ctrl import selt_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_take,
    input  wire logic i_out_free,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_busy
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_COMMIT = 3'd2;
    localparam logic [2:0] S_FINISH = 3'd3;
    localparam logic [2:0] S_WAIT   = 3'd4;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_take) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_WAIT;
            end
            S_WAIT: begin
                if (i_out_free) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |-> !o_busy) else $error("start while busy");
    a_commit_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> $past(o_cmd.scan)) else $error("commit without scan");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd)) else $error("overlapping commands");
endmodule
`default_nettype wire

>>> rtl/selt_dp.sv
// datapath for the lock table: entry memories, valid bits, scan and result
`default_nettype none
module selt_dp import selt_pkg::*; #(
    parameter int unsigned ENTRIES = ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire t_in_item    i_item,
    input  wire logic        i_enabled,
    input  wire logic [15:0] i_max_min,
    input  wire logic [15:0] i_interval,
    output t_sts             o_sts,
    output t_out_item        o_res
);
    localparam int unsigned RESOURCE_BITS = RESOURCE_BITS_DEF;
    localparam int unsigned ROUTE_BITS    = ROUTE_BITS_DEF;
    localparam int unsigned AW   = $clog2(ENTRIES);
    localparam int unsigned CW   = $clog2(ENTRIES + 1);
    localparam int unsigned RECW = 2 + RESOURCE_BITS + ROUTE_BITS + 2 + 32;

    typedef struct packed {
        logic [1:0]               rkind;
        logic [RESOURCE_BITS-1:0] rnum;
        logic [ROUTE_BITS-1:0]    route;
        logic [1:0]               lkind;
        logic [31:0]              expiry;
    } t_rec;

    t_in_item         r_item;
    logic [ENTRIES-1:0] r_valid;
    logic [15:0]      r_ins_cnt;
    logic [31:0]      r_now;
    logic [15:0]      r_countdown;
    logic             r_due;
    logic [AW-1:0]    r_idx;
    logic             r_rd_vld;
    logic [AW-1:0]    r_rd_idx;
    logic             r_rd_last;
    logic [CW-1:0]    r_match_cnt;
    logic [CW-1:0]    r_purged;
    logic             r_free_found;
    logic [AW-1:0]    r_free_idx;
    logic             r_best_found;
    logic [AW-1:0]    r_best_idx;
    logic [15:0]      r_best_age;
    logic [31:0]      r_expiry;
    logic [2:0]       w_status;
    t_out_item        r_res;
    t_out_item        n_res;

    t_rec             w_rd_rec;
    logic [RECW-1:0]  w_rd_raw;
    logic [15:0]      w_rd_seq;
    logic             w_we;
    logic [AW-1:0]    w_addr;
    t_rec             w_wrec;
    logic             w_same_res;
    logic             w_live;
    logic [15:0]      w_age;
    logic [15:0]      w_mins;
    logic [37:0]      w_prod;
    logic [32:0]      w_sum;
    logic             w_rvalid;
    logic [1:0]       w_lk;

    assign w_rd_rec = t_rec'(w_rd_raw);
    assign w_lk     = r_item.lock_kind;

    // write happens only on a grant, at commit
    assign w_we   = i_cmd.commit && r_item.mode == MODE_LOCK && w_status == ST_OK
                    && i_enabled;
    assign w_addr = w_we ? r_free_idx : r_idx;
    assign w_wrec = '{rkind: r_item.resource_kind,
                      rnum: r_item.resource_number[RESOURCE_BITS-1:0],
                      route: r_item.route_number[ROUTE_BITS-1:0],
                      lkind: w_lk, expiry: r_expiry};

    selt_ram #(.WIDTH(RECW), .DEPTH(ENTRIES)) u_rec (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr),
        .i_wdata(RECW'(w_wrec)), .o_rdata(w_rd_raw)
    );
    selt_ram #(.WIDTH(16), .DEPTH(ENTRIES)) u_seq (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr),
        .i_wdata(r_ins_cnt), .o_rdata(w_rd_seq)
    );

    assign w_rvalid   = r_valid[r_rd_idx];
    assign w_same_res = w_rd_rec.rkind == r_item.resource_kind
                        && w_rd_rec.rnum == r_item.resource_number[RESOURCE_BITS-1:0];
    assign w_live     = w_rvalid && (r_now < w_rd_rec.expiry);
    assign w_age      = r_ins_cnt - w_rd_seq;

    assign w_mins = (r_item.timeout_minutes < i_max_min) ? r_item.timeout_minutes
                                                         : i_max_min;
    assign w_prod = ((w_mins == 16'd0) ? 38'd1 : {22'd0, w_mins}) * 38'(SEC_PER_MIN);
    assign w_sum  = {1'b0, r_now} + w_prod[32:0];

    assign o_sts.rd_valid = r_rd_vld;
    assign o_sts.last     = r_rd_vld && r_rd_last;
    assign o_res          = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_ins_cnt   <= '0;
            r_now       <= '0;
            r_countdown <= '0;
            r_rd_vld    <= 1'b0;
        end else begin
            // issue reads one per cycle, then consume registered data
            r_rd_vld <= i_cmd.scan && !(r_rd_vld && r_rd_last);
            if (i_cmd.start) begin
                r_item       <= i_item;
                r_idx        <= '0;
                r_match_cnt  <= '0;
                r_purged     <= '0;
                r_free_found <= 1'b0;
                r_best_found <= 1'b0;
                r_due        <= (i_item.mode == MODE_TICK) && (r_countdown <= 16'd1);
                if (i_item.mode == MODE_TICK) begin
                    r_now   <= r_now + 32'd1;
                    r_countdown <= (r_countdown <= 16'd1) ? i_interval
                                                          : r_countdown - 16'd1;
                end
            end
            if (i_cmd.scan) begin
                r_rd_idx  <= r_idx;
                r_rd_last <= r_idx == AW'(ENTRIES - 1);
                if (r_idx != AW'(ENTRIES - 1)) begin
                    r_idx <= r_idx + AW'(1);
                end
                if (r_rd_vld) begin
                    unique case (r_item.mode)
                        MODE_LOCK: begin
                            if (w_live && w_same_res && !(w_rd_rec.lkind == KIND_SHARED
                                && w_lk == KIND_SHARED)) begin
                                r_match_cnt <= r_match_cnt + CW'(1);
                            end
                            if (!w_rvalid && !r_free_found) begin
                                r_free_found <= 1'b1;
                                r_free_idx   <= r_rd_idx;
                            end
                        end
                        MODE_UNLOCK: begin
                            if (w_rvalid && w_same_res && r_item.resource_kind != RES_INVALID
                                && w_rd_rec.route == r_item.route_number[ROUTE_BITS-1:0]
                                && (!r_best_found || w_age < r_best_age)) begin
                                r_best_found <= 1'b1;
                                r_best_idx   <= r_rd_idx;
                                r_best_age   <= w_age;
                            end
                        end
                        MODE_UNLOCK_ALL: begin
                            if (i_enabled && w_rvalid
                                && w_rd_rec.route == r_item.route_number[ROUTE_BITS-1:0]) begin
                                r_valid[r_rd_idx] <= 1'b0;
                                r_purged <= r_purged + CW'(1);
                            end
                        end
                        MODE_TICK: begin
                            if (i_enabled && r_due && w_rvalid && w_rd_rec.expiry <= r_now) begin
                                r_valid[r_rd_idx] <= 1'b0;
                                r_purged <= r_purged + CW'(1);
                            end
                        end
                        MODE_QUERY: begin
                            if (w_live && w_same_res) begin
                                r_match_cnt <= r_match_cnt + CW'(1);
                            end
                        end
                        default: ;
                    endcase
                end
                if (r_rd_vld && r_rd_last) begin
                    r_expiry <= w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
                end
            end
            if (i_cmd.commit) begin
                if (r_item.mode == MODE_LOCK && w_status == ST_OK && i_enabled) begin
                    r_valid[r_free_idx] <= 1'b1;
                    r_ins_cnt <= r_ins_cnt + 16'd1;
                end
                if (r_item.mode == MODE_UNLOCK && i_enabled && r_best_found) begin
                    r_valid[r_best_idx] <= 1'b0;
                end
            end
        end
    end

    // status from the scan results
    always_comb begin
        w_status = ST_OK;
        unique case (r_item.mode)
            MODE_LOCK: begin
                if (!i_enabled) w_status = ST_DISABLED;
                else if (w_lk == KIND_INVALID) w_status = ST_BAD_LOCK;
                else if (r_item.resource_kind == RES_INVALID) w_status = ST_BAD_RES;
                else if (r_match_cnt != '0) w_status = ST_CONFLICT;
                else if (!r_free_found) w_status = ST_FULL;
            end
            MODE_UNLOCK: begin
                if (!i_enabled) w_status = ST_DISABLED;
                else if (!r_best_found) w_status = ST_NOT_FOUND;
            end
            MODE_UNLOCK_ALL, MODE_TICK: begin
                if (!i_enabled) w_status = ST_DISABLED;
            end
            default: w_status = ST_OK;
        endcase
    end

    always_comb begin
        n_res        = '0;
        n_res.status = w_status;
        unique case (r_item.mode)
            MODE_LOCK: begin
                if (w_status == ST_CONFLICT) n_res.conflict_count = 7'(r_match_cnt);
                if (w_status == ST_OK) n_res.lease_end = r_expiry;
            end
            MODE_UNLOCK_ALL, MODE_TICK: n_res.purged_count = 7'(r_purged);
            MODE_QUERY: begin
                n_res.live_lock_count = 7'(r_match_cnt);
                n_res.is_locked       = r_match_cnt != '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_res <= n_res;
        end
    end

    a_grant_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> !r_valid[r_free_idx]) else $error("grant into a valid slot");
    a_grant_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> r_valid[$past(r_free_idx)]) else $error("grant lost");
    a_scan_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> i_cmd.scan) else $error("read data outside scan");
endmodule
`default_nettype wire

>>> rtl/shared_exclusive_lock_table.sv
// top level of the shared/exclusive lock table
`default_nettype none
// Each transfer (lock, unlock, unlock-all, tick or query) walks the whole entry
// table through the record memory, one entry per cycle; one item is in work at
// a time and the input stalls until its result has been taken.
// The entry table is empty after reset with no clearing pass. Registers are
// written only while the block is idle.
module shared_exclusive_lock_table import selt_pkg::*; #(
    parameter int unsigned ENTRIES = ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_in_item    i_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_out_item        o_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    logic        r_enabled;
    logic [15:0] r_max_min;
    logic [15:0] r_interval;
    logic        r_out_vld;
    logic        w_busy;
    logic        w_take;
    t_cmd        w_cmd;
    t_sts        w_sts;

    assign o_stall     = w_busy || r_out_vld;
    assign w_take      = i_valid && !o_stall;
    assign o_cfg_ready = !w_busy && !r_out_vld;
    assign o_valid     = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled  <= 1'b0;
            r_max_min  <= 16'd1440;
            r_interval <= 16'd30;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_ENABLED:  r_enabled  <= i_cfg_data[0];
                    CFG_MAX_MIN:  r_max_min  <= i_cfg_data;
                    CFG_INTERVAL: r_interval <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_cmd.finish) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    selt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_take(w_take),
        .i_out_free(!r_out_vld), .i_sts(w_sts), .o_cmd(w_cmd), .o_busy(w_busy)
    );

    selt_dp #(.ENTRIES(ENTRIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_item(i_data),
        .i_enabled(r_enabled), .i_max_min(r_max_min), .i_interval(r_interval),
        .o_sts(w_sts), .o_res(o_data)
    );

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> w_busy) else $error("item not started");
    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> !r_out_vld) else $error("result overwritten");
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall) |=> r_out_vld) else $error("stalled result dropped");
endmodule
`default_nettype wire

>>> bench/shared_exclusive_lock_table_tb.sv
// self-checking testbench for the shared/exclusive lock table: directed table, random traffic
`default_nettype none
module shared_exclusive_lock_table_tb;
    import selt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS   = 64;
    localparam int DRAIN_WAIT  = 80;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DIS_ROWS    = 5;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item result;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_in_item    i_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_out_item   o_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    shared_exclusive_lock_table u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // shadow lock table
    bit          slot_used [NUM_SLOTS];
    logic [1:0]  slot_rkind [NUM_SLOTS];
    logic [11:0] slot_rnum [NUM_SLOTS];
    logic [7:0]  slot_route [NUM_SLOTS];
    logic [1:0]  slot_lkind [NUM_SLOTS];
    logic [31:0] slot_expiry [NUM_SLOTS];
    logic [15:0] slot_seq [NUM_SLOTS];
    logic [15:0] seq_next = '0;
    logic [31:0] now_sec = '0;
    logic [15:0] sweep_cdown = '0;
    logic        reg_enabled = 1'b0;
    logic [15:0] reg_max_min = 16'd1440;
    logic [15:0] reg_interval = 16'd30;

    t_out_item   pending_results[$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          valid_high = 0;
    bit          hold_request = 0;
    int          stall_left = 0;

    function automatic t_out_item predict_result(t_in_item it);
        t_out_item r;
        int        free_slot;
        int        best;
        logic [15:0] age;
        logic [15:0] best_age;
        logic [15:0] mins;
        longint    exp_sum;
        bit        due;
        r = '0;
        free_slot = -1;
        best = -1;
        best_age = '0;
        case (it.mode)
            MODE_LOCK: begin
                if (!reg_enabled) r.status = ST_DISABLED;
                else if (it.lock_kind == KIND_INVALID) r.status = ST_BAD_LOCK;
                else if (it.resource_kind == RES_INVALID) r.status = ST_BAD_RES;
                else begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (slot_used[i] && now_sec < slot_expiry[i]
                                && slot_rkind[i] == it.resource_kind
                                && slot_rnum[i] == it.resource_number
                                && !(slot_lkind[i] == KIND_SHARED
                                     && it.lock_kind == KIND_SHARED))
                            r.conflict_count++;
                        if (!slot_used[i] && free_slot < 0) free_slot = i;
                    end
                    if (r.conflict_count != 0) r.status = ST_CONFLICT;
                    else if (free_slot < 0) r.status = ST_FULL;
                    else begin
                        mins = (it.timeout_minutes < reg_max_min) ? it.timeout_minutes
                                                                   : reg_max_min;
                        if (mins == 0) mins = 1;
                        exp_sum = longint'(now_sec) + longint'(mins) * SEC_PER_MIN;
                        r.lease_end = (exp_sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                : exp_sum[31:0];
                        slot_used[free_slot]   = 1;
                        slot_rkind[free_slot]  = it.resource_kind;
                        slot_rnum[free_slot]   = it.resource_number;
                        slot_route[free_slot]  = it.route_number;
                        slot_lkind[free_slot]  = it.lock_kind;
                        slot_expiry[free_slot] = r.lease_end;
                        slot_seq[free_slot]    = seq_next;
                        seq_next++;
                    end
                end
            end
            MODE_UNLOCK: begin
                if (!reg_enabled) r.status = ST_DISABLED;
                else begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (slot_used[i] && slot_rkind[i] == it.resource_kind
                                && slot_rnum[i] == it.resource_number
                                && slot_route[i] == it.route_number) begin
                            age = seq_next - slot_seq[i];
                            if (best < 0 || age < best_age) begin
                                best = i;
                                best_age = age;
                            end
                        end
                    end
                    if (best < 0) r.status = ST_NOT_FOUND;
                    else slot_used[best] = 0;
                end
            end
            MODE_UNLOCK_ALL: begin
                if (!reg_enabled) r.status = ST_DISABLED;
                else begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (slot_used[i] && slot_route[i] == it.route_number) begin
                            slot_used[i] = 0;
                            r.purged_count++;
                        end
                    end
                end
            end
            MODE_TICK: begin
                now_sec++;
                due = (sweep_cdown <= 1);
                if (due) sweep_cdown = reg_interval;
                else sweep_cdown--;
                if (!reg_enabled) r.status = ST_DISABLED;
                else if (due) begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (slot_used[i] && slot_expiry[i] <= now_sec) begin
                            slot_used[i] = 0;
                            r.purged_count++;
                        end
                    end
                end
            end
            MODE_QUERY: begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (slot_used[i] && now_sec < slot_expiry[i]
                            && slot_rkind[i] == it.resource_kind
                            && slot_rnum[i] == it.resource_number)
                        r.live_lock_count++;
                r.is_locked = (r.live_lock_count != 0);
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic t_in_item make_item(logic [2:0] md, logic [1:0] rk, logic [11:0] rn,
                                           logic [7:0] rt, logic [1:0] lk, logic [15:0] tmo);
        t_in_item it;
        it.mode = md;
        it.resource_kind = rk;
        it.resource_number = rn;
        it.route_number = rt;
        it.lock_kind = lk;
        it.timeout_minutes = tmo;
        return it;
    endfunction

    function automatic t_row typed_row(t_in_item it, logic [2:0] st);
        t_row rw;
        rw.item = it;
        rw.typed = 1;
        rw.result = '0;
        rw.result.status = st;
        return rw;
    endfunction

    function automatic t_row predicted_row(t_in_item it);
        t_row rw;
        rw.item = it;
        rw.typed = 0;
        rw.result = '0;
        return rw;
    endfunction

    task automatic send_item(t_in_item it, bit typed, t_out_item typed_result);
        t_out_item p;
        int gap;
        i_data <= it;
        if (!valid_high) i_valid <= 1'b1;
        valid_high = 1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        p = predict_result(it);
        pending_results.push_back(typed ? typed_result : p);
        gap = ($urandom_range(0, 9) < 5) ? 0 :
              ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            valid_high = 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        if (valid_high) begin
            i_valid <= 1'b0;
            valid_high = 0;
        end
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_ENABLED:  reg_enabled = val[0];
            CFG_MAX_MIN:  reg_max_min = val;
            CFG_INTERVAL: reg_interval = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int count);
        t_in_item it;
        int sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            it.resource_kind = 2'($urandom_range(0, 2));
            it.resource_number = ($urandom_range(0, 9) == 0) ? 12'($urandom)
                                                              : 12'($urandom_range(0, 7));
            it.route_number = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                           : 8'($urandom_range(0, 7));
            it.lock_kind = 2'($urandom_range(0, 2));
            it.timeout_minutes = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                              : 16'($urandom_range(0, 3));
            if (sel < 35) it.mode = MODE_LOCK;
            else if (sel < 50) it.mode = MODE_UNLOCK;
            else if (sel < 54) it.mode = MODE_UNLOCK_ALL;
            else if (sel < 80) it.mode = MODE_TICK;
            else if (sel < 94) it.mode = MODE_QUERY;
            else begin
                it.mode = 3'($urandom_range(0, 7));
                it.resource_kind = 2'($urandom_range(0, 3));
                it.lock_kind = 2'($urandom_range(0, 3));
            end
            if (n == count / 2) hold_request = 1;
            send_item(it, 0, '0);
        end
    endtask

    // receiver side stall, with one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_request && stall_left == 0) begin
            hold_request <= 0;
            stall_left <= 500;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 9) < 3) begin
            stall_left <= ($urandom_range(0, 24) == 0) ? $urandom_range(20, 80)
                                                       : $urandom_range(0, 3);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_data);
            end else begin
                want = pending_results.pop_front();
                if (o_data.status !== want.status
                        || o_data.conflict_count !== want.conflict_count
                        || o_data.is_locked !== want.is_locked
                        || o_data.live_lock_count !== want.live_lock_count
                        || o_data.lease_end !== want.lease_end
                        || o_data.purged_count !== want.purged_count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p actual %p", want, o_data);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        t_row lock_rows[$];
        lock_rows.push_back(typed_row(make_item(MODE_LOCK, 0, 1, 1, KIND_EXCLUSIVE, 5),
                                      ST_DISABLED));
        lock_rows.push_back(typed_row(make_item(MODE_QUERY, 0, 1, 0, 0, 0), ST_OK));
        lock_rows.push_back(typed_row(make_item(MODE_TICK, 0, 0, 0, 0, 0), ST_DISABLED));
        lock_rows.push_back(typed_row(make_item(MODE_UNLOCK, 0, 1, 1, 0, 0), ST_DISABLED));
        lock_rows.push_back(typed_row(make_item(MODE_UNLOCK_ALL, 0, 0, 1, 0, 0),
                                      ST_DISABLED));
        lock_rows.push_back(typed_row(make_item(MODE_LOCK, 0, 1, 1, KIND_INVALID, 5),
                                      ST_BAD_LOCK));
        lock_rows.push_back(typed_row(make_item(MODE_LOCK, RES_INVALID, 1, 1, KIND_SHARED, 5),
                                      ST_BAD_RES));
        lock_rows.push_back(typed_row(make_item(MODE_LOCK, RES_INVALID, 1, 1, KIND_INVALID, 5),
                                      ST_BAD_LOCK));
        lock_rows.push_back(predicted_row(make_item(MODE_LOCK, 0, 12'hFFF, 8'hFF,
                                                    KIND_EXCLUSIVE, 16'hFFFF)));
        lock_rows.push_back(predicted_row(make_item(MODE_LOCK, 0, 12'hFFF, 3, KIND_SHARED, 2)));
        lock_rows.push_back(predicted_row(make_item(MODE_LOCK, 1, 0, 1, KIND_SHARED, 0)));
        lock_rows.push_back(predicted_row(make_item(MODE_LOCK, 1, 0, 1, KIND_SHARED, 1)));
        lock_rows.push_back(predicted_row(make_item(MODE_LOCK, 1, 0, 4, KIND_EXCLUSIVE, 1)));
        lock_rows.push_back(predicted_row(make_item(MODE_LOCK, 2, 0, 2, KIND_OVERLAP, 1)));
        lock_rows.push_back(predicted_row(make_item(MODE_LOCK, 2, 0, 2, KIND_SHARED, 1)));
        lock_rows.push_back(predicted_row(make_item(MODE_QUERY, 1, 0, 0, 0, 0)));
        lock_rows.push_back(predicted_row(make_item(MODE_QUERY, 0, 12'hFFF, 0, 0, 0)));
        lock_rows.push_back(predicted_row(make_item(MODE_UNLOCK, 1, 0, 1, 0, 0)));
        lock_rows.push_back(typed_row(make_item(MODE_UNLOCK, RES_INVALID, 0, 1, 0, 0),
                                      ST_NOT_FOUND));
        lock_rows.push_back(typed_row(make_item(MODE_UNLOCK, 2, 9, 9, 0, 0), ST_NOT_FOUND));
        lock_rows.push_back(predicted_row(make_item(MODE_UNLOCK_ALL, 0, 0, 2, 0, 0)));
        lock_rows.push_back(predicted_row(make_item(MODE_UNLOCK_ALL, 0, 0, 200, 0, 0)));
        lock_rows.push_back(predicted_row(make_item(MODE_TICK, 0, 0, 0, 0, 0)));
        lock_rows.push_back(typed_row(make_item(3'd5, 0, 1, 1, 0, 1), ST_OK));
        lock_rows.push_back(typed_row(make_item(3'd7, 3, 12'hFFF, 8'hFF, 3, 16'hFFFF), ST_OK));

        for (int i = 0; i < NUM_SLOTS; i++) slot_used[i] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < lock_rows.size(); r++) begin
            if (r == DIS_ROWS) write_reg(CFG_ENABLED, 16'd1);
            send_item(lock_rows[r].item, lock_rows[r].typed, lock_rows[r].result);
        end

        random_phase(500);
        write_reg(CFG_MAX_MIN, 16'd1);
        write_reg(CFG_INTERVAL, 16'd1);
        random_phase(400);
        write_reg(CFG_MAX_MIN, 16'hFFFF);
        write_reg(CFG_INTERVAL, 16'hFFFF);
        random_phase(400);
        write_reg(CFG_MAX_MIN, 16'd0);
        write_reg(CFG_INTERVAL, 16'd0);
        random_phase(350);
        write_reg(CFG_ENABLED, 16'd0);
        write_reg(CFG_MAX_MIN, 16'd1440);
        write_reg(CFG_INTERVAL, 16'd3);
        random_phase(100);
        write_reg(CFG_ENABLED, 16'd1);
        random_phase(100);

        if (valid_high) i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
rtl/selt_pkg.sv
rtl/selt_ram.sv
rtl/selt_ctrl.sv
rtl/selt_dp.sv
rtl/shared_exclusive_lock_table.sv
bench/shared_exclusive_lock_table_tb.sv
